/* rtl/utf8_to_code_point_decoder_macros.svh */
// Assertion macros used by the UTF-8 decoder RTL.
`ifndef UTF8_TO_CODE_POINT_DECODER_MACROS_SVH
`define UTF8_TO_CODE_POINT_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define U2CP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2cp assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define U2CP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2cp assertion failed");
`else
`define U2CP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define U2CP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/u2cp_pkg.sv */
// Types, constants and lead-byte decoding for the UTF-8 decoder.
package u2cp_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  localparam logic [20:0] REPL_CP     = 21'h00FFFD;
  localparam logic [20:0] MAX_CP      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] MIN_CP_LEN2 = 21'h000080;
  localparam logic [20:0] MIN_CP_LEN3 = 21'h000800;
  localparam logic [20:0] MIN_CP_LEN4 = 21'h010000;

  // Sequence length declared by a lead byte; zero marks a byte that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    begin
      if (b[7] == 1'b0) begin
        len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        len = 3'd4;
      end else begin
        len = 3'd0;
      end
      return len;
    end
  endfunction

endpackage

/* rtl/utf8_to_code_point_decoder.sv */
// Top level: UTF-8 byte stream to Unicode code point decoder with U+FFFD replacement.
//
//  channel | direction | tdata                                | tlast        | tuser
//  --------+-----------+--------------------------------------+--------------+----------
//  in_     | slave     | [7:0] text_byte                      | end_of_text  | -
//  out_    | master    | [20:0] code_point, [21] is_replacement| last_of_run | text_done
//
// An item is loaded while the sequencer is idle; the single sequence decoder and the byte
// shifter behind it then release one result per step until no byte is left or a short
// sequence waits for more. in_tready is high only while the sequencer is idle.
// A result waiting in the output register stalls the decoder until it is taken.
// rst_n is synchronous and clears the sequencer, the held byte count and out_tvalid.

`include "utf8_to_code_point_decoder_macros.svh"

module utf8_to_code_point_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [21] is_replacement, [23:22] zero
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // text_done
);
  import u2cp_pkg::*;

  state_t            state_r, state_nxt;
  logic [3:0][7:0]   buf_r, buf_nxt;
  logic [2:0]        n_r, n_nxt;
  logic              eot_r, eot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [20:0]       cp_r, cp_nxt;
  logic              repl_r, repl_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;

  logic [2:0]        len;
  logic              c1, c2, c3;
  logic              emit, stop, ok;
  logic [2:0]        consumed;
  logic [2:0]        n_left;
  logic [20:0]       raw_cp;
  logic [20:0]       res_cp;
  logic              res_repl;
  logic [31:0]       shifted;
  logic [2:0]        nxt_len;
  logic              more;
  logic              go;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, repl_r, cp_r};
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

  // One sequence at the buffer head is decoded per cycle, unless the output stalls.
  always_comb begin
    len      = lead_len(buf_r[0]);
    c1       = (buf_r[1][7:6] == 2'b10);
    c2       = (buf_r[2][7:6] == 2'b10);
    c3       = (buf_r[3][7:6] == 2'b10);
    emit     = 1'b0;
    stop     = 1'b0;
    ok       = 1'b0;
    consumed = 3'd0;
    raw_cp   = {14'd0, buf_r[0][6:0]};
    res_cp   = REPL_CP;
    res_repl = 1'b1;

    case (len)
      3'd2:    raw_cp = {10'd0, buf_r[0][4:0], buf_r[1][5:0]};
      3'd3:    raw_cp = {5'd0, buf_r[0][3:0], buf_r[1][5:0], buf_r[2][5:0]};
      3'd4:    raw_cp = {buf_r[0][2:0], buf_r[1][5:0], buf_r[2][5:0], buf_r[3][5:0]};
      default: raw_cp = {14'd0, buf_r[0][6:0]};
    endcase

    if (len == 3'd0) begin
      emit     = 1'b1;
      consumed = 3'd1;
    end else if (len > n_r) begin
      // The declared sequence is still short: wait, or flush it at end of text.
      if (eot_r) begin
        emit     = 1'b1;
        consumed = n_r;
      end else begin
        stop = 1'b1;
      end
    end else begin
      emit = 1'b1;
      if (len >= 3'd2 && !c1) begin
        consumed = 3'd1;
      end else if (len >= 3'd3 && !c2) begin
        consumed = 3'd2;
      end else if (len == 3'd4 && !c3) begin
        consumed = 3'd3;
      end else begin
        consumed = len;
        ok       = 1'b1;
      end
      if (ok) begin
        if ((len == 3'd2 && raw_cp < MIN_CP_LEN2) ||
            (len == 3'd3 && raw_cp < MIN_CP_LEN3) ||
            (len == 3'd4 && raw_cp < MIN_CP_LEN4) ||
            (raw_cp >= SURR_LO && raw_cp <= SURR_HI) ||
            (raw_cp > MAX_CP)) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        res_cp   = raw_cp;
        res_repl = 1'b0;
      end
    end

    n_left  = n_r - consumed;
    shifted = buf_r >> {consumed, 3'b000};
    // Peek at the next lead byte to tell whether another result follows.
    nxt_len = lead_len(shifted[7:0]);
    more    = (n_left != 3'd0) && ((nxt_len == 3'd0) || (nxt_len <= n_left) || eot_r);
  end

  assign go = (state_r == ST_BUSY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    n_nxt         = n_r;
    eot_nxt       = eot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cp_nxt        = cp_r;
    repl_nxt      = repl_r;
    last_nxt      = last_r;
    done_nxt      = done_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          buf_nxt[n_r[1:0]] = in_tdata;
          n_nxt             = n_r + 3'd1;
          eot_nxt           = in_tlast;
          state_nxt         = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (go) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
            cp_nxt        = res_cp;
            repl_nxt      = res_repl;
            last_nxt      = !more;
            done_nxt      = !more && eot_r;
          end
          buf_nxt = shifted;
          n_nxt   = n_left;
          if (stop || n_left == 3'd0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= 3'd0;
      eot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      eot_r       <= eot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    cp_r   <= cp_nxt;
    repl_r <= repl_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  `U2CP_ASSERT_NOW(a_idle_room, clk, rst_n, state_r == ST_IDLE, n_r <= 3'd3)
  `U2CP_ASSERT_NOW(a_busy_has_bytes, clk, rst_n, state_r == ST_BUSY, n_r != 3'd0)
  `U2CP_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid_r && done_r, last_r)
  `U2CP_ASSERT_NXT(a_eot_clears, clk, rst_n, go && eot_r, n_r == 3'd0 || state_r == ST_BUSY)

endmodule
